// ===== sv/gmmbg_pkg.sv =====
// ----------------------------------------------------------------------------
// gmmbg_pkg
// shared types, register indexes and helpers of the gaussian mixture
// background updater
// ----------------------------------------------------------------------------
package gmmbg_pkg;

   localparam int PIXEL_INDEX_W = 19;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 17;
   localparam int DIV_Q_W       = 17;
   localparam int DIV_N_W       = 33;
   localparam int DIV_D_W       = 20;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LEARNING_RATE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKGROUND_RATIO = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MATCH_BG         = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MATCH_FIT        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_VARIANCE_INITIAL = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_VARIANCE_FLOOR   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_VARIANCE_CEILING = 3'd6;

   // register reset values
   localparam logic [16:0] RST_LEARNING_RATE    = 17'd655;
   localparam logic [16:0] RST_BACKGROUND_RATIO = 17'd58982;
   localparam logic [11:0] RST_MATCH_BG         = 12'd256;
   localparam logic [11:0] RST_MATCH_FIT        = 12'd144;
   localparam logic [15:0] RST_VARIANCE_INITIAL = 16'd3840;
   localparam logic [15:0] RST_VARIANCE_FLOOR   = 16'd1024;
   localparam logic [15:0] RST_VARIANCE_CEILING = 16'd19200;

   localparam logic [16:0] ONE_Q16    = 17'h10000;
   localparam logic [16:0] WEIGHT_MAX = 17'h1FFFF;

   // color channel codes
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef struct packed {
      logic [PIXEL_INDEX_W-1:0] pixel_index;
      logic [7:0]               red;
      logic [7:0]               green;
      logic [7:0]               blue;
   } req_type;

   typedef struct packed {
      logic       foreground;
      logic [7:0] bg_red;
      logic [7:0] bg_green;
      logic [7:0] bg_blue;
   } rsp_type;

   typedef struct packed {
      logic [16:0] learning_rate;
      logic [16:0] background_ratio;
      logic [11:0] match_threshold_bg;
      logic [11:0] match_threshold_fit;
      logic [15:0] variance_initial;
      logic [15:0] variance_floor;
      logic [15:0] variance_ceiling;
   } cfg_type;

   typedef struct packed {
      logic [16:0] weight;
      logic [15:0] variance;
      logic [15:0] mean_r;
      logic [15:0] mean_g;
      logic [15:0] mean_b;
   } mode_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_Q_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_WRAP,
      S_READ,
      S_LOAD,
      S_DECAY,
      S_DIST,
      S_TBG,
      S_TFIT,
      S_TEST,
      S_KWAIT,
      S_MEAN,
      S_VAR,
      S_CLAMP,
      S_SAVE,
      S_BUBBLE,
      S_NEXT,
      S_RENORM,
      S_RNWAIT,
      S_ADD,
      S_ADECAY,
      S_WRITE
   } state_type;

   function automatic logic [15:0] mean_get(mode_type m, logic [1:0] ch);
      logic [15:0] r;
      case (ch)
         CH_RED:   r = m.mean_r;
         CH_GREEN: r = m.mean_g;
         default:  r = m.mean_b;
      endcase
      return r;
   endfunction

   function automatic mode_type mean_set(mode_type m, logic [1:0] ch, logic [15:0] v);
      mode_type r;
      r = m;
      case (ch)
         CH_RED:   r.mean_r = v;
         CH_GREEN: r.mean_g = v;
         default:  r.mean_b = v;
      endcase
      return r;
   endfunction

   // pixel channel as q8.8
   function automatic logic [15:0] pixel_get(req_type q, logic [1:0] ch);
      logic [15:0] r;
      case (ch)
         CH_RED:   r = {q.red, 8'h00};
         CH_GREEN: r = {q.green, 8'h00};
         default:  r = {q.blue, 8'h00};
      endcase
      return r;
   endfunction

endpackage

// ===== sv/gmmbg_mode_ram.sv =====
// ----------------------------------------------------------------------------
// gmmbg_mode_ram
// single port pair model store, one row per pixel, registered read
// ----------------------------------------------------------------------------
module gmmbg_mode_ram #(
   parameter int DEPTH  = 524288,
   parameter int WIDTH  = 408,
   parameter int ADDR_W = 19
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/gmmbg_divider.sv =====
// ----------------------------------------------------------------------------
// gmmbg_divider
// restoring divider, one quotient bit per cycle, quotient below 2^17
// ----------------------------------------------------------------------------
module gmmbg_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  gmmbg_pkg::div_req_type  div_req,
   output gmmbg_pkg::div_rsp_type  div_rsp
);

   localparam int QW  = gmmbg_pkg::DIV_Q_W;
   localparam int NW  = gmmbg_pkg::DIV_N_W;
   localparam int DW  = gmmbg_pkg::DIV_D_W;
   localparam int SW  = DW + QW - 1;
   localparam int CW  = $clog2(QW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] rem_ff, rem_in;
   logic [SW-1:0] den_ff, den_in;
   logic [QW-1:0] quo_ff, quo_in;

   always_comb begin
      logic take;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      take    = 1'b0;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(QW - 1);
         rem_in  = div_req.dividend;
         den_in  = {div_req.divisor, {(QW-1){1'b0}}};
         quo_in  = '0;
      end else if (busy_ff) begin
         take = (SW'(rem_ff) >= den_ff);
         if (take) begin
            rem_in = rem_ff - NW'(den_ff);
         end
         quo_in = {quo_ff[QW-2:0], take};
         den_in = den_ff >> 1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== sv/gmmbg_csr.sv =====
// ----------------------------------------------------------------------------
// gmmbg_csr
// configuration registers, write only
// ----------------------------------------------------------------------------
module gmmbg_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [gmmbg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [gmmbg_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output gmmbg_pkg::cfg_type                  cfg
);

   gmmbg_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            gmmbg_pkg::CSR_LEARNING_RATE:    cfg_in.learning_rate       = csr_wdata;
            gmmbg_pkg::CSR_BACKGROUND_RATIO: cfg_in.background_ratio    = csr_wdata;
            gmmbg_pkg::CSR_MATCH_BG:         cfg_in.match_threshold_bg  = csr_wdata[11:0];
            gmmbg_pkg::CSR_MATCH_FIT:        cfg_in.match_threshold_fit = csr_wdata[11:0];
            gmmbg_pkg::CSR_VARIANCE_INITIAL: cfg_in.variance_initial    = csr_wdata[15:0];
            gmmbg_pkg::CSR_VARIANCE_FLOOR:   cfg_in.variance_floor      = csr_wdata[15:0];
            gmmbg_pkg::CSR_VARIANCE_CEILING: cfg_in.variance_ceiling    = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.learning_rate       <= gmmbg_pkg::RST_LEARNING_RATE;
         cfg_ff.background_ratio    <= gmmbg_pkg::RST_BACKGROUND_RATIO;
         cfg_ff.match_threshold_bg  <= gmmbg_pkg::RST_MATCH_BG;
         cfg_ff.match_threshold_fit <= gmmbg_pkg::RST_MATCH_FIT;
         cfg_ff.variance_initial    <= gmmbg_pkg::RST_VARIANCE_INITIAL;
         cfg_ff.variance_floor      <= gmmbg_pkg::RST_VARIANCE_FLOOR;
         cfg_ff.variance_ceiling    <= gmmbg_pkg::RST_VARIANCE_CEILING;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/pixel_gaussian_mixture_bg_update.sv =====
// ----------------------------------------------------------------------------
// pixel_gaussian_mixture_bg_update
// per pixel gaussian mixture background model, update and foreground flag
// ----------------------------------------------------------------------------
// One pixel beat at a time is taken, its model row is read from the model
// store, the modes are walked by a sequencer and the row is written back
// before the next pixel is taken. A beat passes through accept, the index
// wrap steps, read, load, a decay, distance and fit test per mode visited
// before the fit and a decay per mode after it, then for the matching mode
// the mean and variance update and its move into place, with k from the
// shared 17-step divider; renormalization runs each mode through that same
// divider, then the add check, where a new mode brings decay and sorting,
// and the write back. The result beat sits in an output register, so the
// next pixel may be taken while it waits. After reset a clearing pass
// writes every row once, during which no pixel is taken; configuration
// writes are taken at any time.
module pixel_gaussian_mixture_bg_update #(
   parameter int MAX_MODES   = 5,
   parameter int PIXEL_COUNT = 524288
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  gmmbg_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output gmmbg_pkg::rsp_type                  rsp_data,
   input  logic                                csr_wen,
   input  logic [gmmbg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [gmmbg_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int PW         = gmmbg_pkg::PIXEL_INDEX_W;
   localparam int ADDR_W     = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
   localparam int CNT_W      = $clog2(MAX_MODES + 1);
   localparam int IDX_W      = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
   localparam int MODE_W     = $bits(gmmbg_pkg::mode_type);
   localparam int ROW_W      = CNT_W + MAX_MODES * MODE_W;
   // index wrap: largest quotient of an index by the pixel count
   localparam int QMAX       = ((2 ** PW) - 1) / PIXEL_COUNT;
   localparam int WRAP_STEPS = $clog2(QMAX + 1);
   localparam int WRAP_W     = (WRAP_STEPS > 1) ? $clog2(WRAP_STEPS) : 1;
   localparam int SUB_W      = PW + 4;

   gmmbg_pkg::cfg_type     cfg;
   gmmbg_pkg::div_req_type div_req;
   gmmbg_pkg::div_rsp_type div_rsp;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [ROW_W-1:0]  ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [ROW_W-1:0]  ram_rd_data;

   gmmbg_pkg::state_type state_ff, state_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   gmmbg_pkg::req_type   req_ff, req_in;
   logic [PW-1:0]        idx_ff, idx_in;
   logic [WRAP_W-1:0]    wrap_ff, wrap_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   gmmbg_pkg::mode_type  modes_ff [MAX_MODES];
   gmmbg_pkg::mode_type  modes_in [MAX_MODES];
   logic [IDX_W-1:0]     mi_ff, mi_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   logic [1:0]           ch_ff, ch_in;
   logic [17:0]          weight_ff, weight_in;
   logic [19:0]          total_ff, total_in;
   logic [33:0]          dist_ff, dist_in;
   logic [27:0]          thr_ff, thr_in;
   logic [16:0]          k_ff, k_in;
   logic [25:0]          step_ff, step_in;
   logic                 neg_ff, neg_in;
   logic                 fits_ff, fits_in;
   logic                 bg_ff, bg_in;
   logic                 bub_add_ff, bub_add_in;
   gmmbg_pkg::rsp_type   rsp_ff, rsp_in;

   // alpha clamped to one, and its complement
   logic [16:0] alpha;
   logic [16:0] alpha_c;
   assign alpha   = (cfg.learning_rate > gmmbg_pkg::ONE_Q16) ? gmmbg_pkg::ONE_Q16
                                                              : cfg.learning_rate;
   assign alpha_c = gmmbg_pkg::ONE_Q16 - alpha;

   gmmbg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gmmbg_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   gmmbg_mode_ram #(
      .DEPTH  (PIXEL_COUNT),
      .WIDTH  (ROW_W),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall = (state_ff != gmmbg_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sequencer: one pass over the stored modes of a pixel
   always_comb begin
      logic [SUB_W-1:0]    wrap_sub;
      logic [16:0]         d_ch;
      logic [15:0]         mag16;
      logic [15:0]         mean_v;
      logic [15:0]         px_v;
      logic [33:0]         prod34;
      logic [32:0]         prod33;
      logic [42:0]         prod43;
      logic [26:0]         d_var;
      logic [25:0]         mag26;
      logic [27:0]         vn;
      logic [17:0]         wsum;
      logic [16:0]         wsat;
      logic [IDX_W-1:0]    add_idx;
      logic [CNT_W-1:0]    cnt_rd;
      gmmbg_pkg::mode_type tmp;

      state_in     = state_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      wrap_in      = wrap_ff;
      n_in         = n_ff;
      modes_in     = modes_ff;
      mi_in        = mi_ff;
      pos_in       = pos_ff;
      ch_in        = ch_ff;
      weight_in    = weight_ff;
      total_in     = total_ff;
      dist_in      = dist_ff;
      thr_in       = thr_ff;
      k_in         = k_ff;
      step_in      = step_ff;
      neg_in       = neg_ff;
      fits_in      = fits_ff;
      bg_in        = bg_ff;
      bub_add_in   = bub_add_ff;
      rsp_in       = rsp_ff;

      ram_wr_en    = 1'b0;
      ram_wr_addr  = ADDR_W'(idx_ff);
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = ADDR_W'(idx_ff);
      div_req      = '0;

      wrap_sub = SUB_W'(PIXEL_COUNT) << wrap_ff;
      d_ch     = '0;
      mag16    = '0;
      mean_v   = '0;
      px_v     = '0;
      prod34   = '0;
      prod33   = '0;
      prod43   = '0;
      d_var    = '0;
      mag26    = '0;
      vn       = '0;
      wsum     = '0;
      wsat     = weight_ff[17] ? gmmbg_pkg::WEIGHT_MAX : weight_ff[16:0];
      add_idx  = '0;
      cnt_rd   = '0;
      tmp      = '0;

      // result beat leaves
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         gmmbg_pkg::S_CLEAR: begin
            // every row gets a zero mode count
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(PIXEL_COUNT - 1)) begin
               state_in = gmmbg_pkg::S_IDLE;
            end
         end

         gmmbg_pkg::S_IDLE: begin
            if (req_valid) begin
               req_in  = req_data;
               idx_in  = req_data.pixel_index;
               wrap_in = WRAP_W'(WRAP_STEPS > 0 ? WRAP_STEPS - 1 : 0);
               state_in = (WRAP_STEPS > 0) ? gmmbg_pkg::S_WRAP : gmmbg_pkg::S_READ;
            end
         end

         gmmbg_pkg::S_WRAP: begin
            // index modulo pixel count, one shifted subtract a cycle
            if (SUB_W'(idx_ff) >= wrap_sub) begin
               idx_in = idx_ff - PW'(wrap_sub);
            end
            if (wrap_ff == '0) begin
               state_in = gmmbg_pkg::S_READ;
            end else begin
               wrap_in = wrap_ff - WRAP_W'(1);
            end
         end

         gmmbg_pkg::S_READ: begin
            ram_rd_en = 1'b1;
            state_in  = gmmbg_pkg::S_LOAD;
         end

         gmmbg_pkg::S_LOAD: begin
            for (int i = 0; i < MAX_MODES; i++) begin
               modes_in[i] = ram_rd_data[i*MODE_W +: MODE_W];
            end
            cnt_rd   = ram_rd_data[ROW_W-1 -: CNT_W];
            n_in     = (cnt_rd > CNT_W'(MAX_MODES)) ? CNT_W'(MAX_MODES) : cnt_rd;
            total_in = '0;
            fits_in  = 1'b0;
            bg_in    = 1'b0;
            mi_in    = '0;
            state_in = (n_in == '0) ? gmmbg_pkg::S_RENORM : gmmbg_pkg::S_DECAY;
         end

         gmmbg_pkg::S_DECAY: begin
            prod34    = 34'(alpha_c) * 34'(modes_ff[mi_ff].weight);
            weight_in = {1'b0, prod34[32:16]};
            dist_in   = '0;
            ch_in     = gmmbg_pkg::CH_RED;
            state_in  = fits_ff ? gmmbg_pkg::S_SAVE : gmmbg_pkg::S_DIST;
         end

         gmmbg_pkg::S_DIST: begin
            // squared distance, one channel a cycle
            mean_v  = gmmbg_pkg::mean_get(modes_ff[mi_ff], ch_ff);
            px_v    = gmmbg_pkg::pixel_get(req_ff, ch_ff);
            d_ch    = {1'b0, mean_v} - {1'b0, px_v};
            mag16   = d_ch[16] ? 16'(-d_ch) : d_ch[15:0];
            dist_in = dist_ff + 34'(32'(mag16) * 32'(mag16));
            ch_in   = ch_ff + 2'd1;
            if (ch_ff == gmmbg_pkg::CH_BLUE) begin
               state_in = gmmbg_pkg::S_TBG;
            end
         end

         gmmbg_pkg::S_TBG: begin
            thr_in   = 28'(cfg.match_threshold_bg) * 28'(modes_ff[mi_ff].variance);
            state_in = gmmbg_pkg::S_TFIT;
         end

         gmmbg_pkg::S_TFIT: begin
            // background when near while the weight above is still small
            if ((total_ff < 20'(cfg.background_ratio)) &&
                (dist_ff < {2'b00, thr_ff, 4'h0})) begin
               bg_in = 1'b1;
            end
            thr_in   = 28'(cfg.match_threshold_fit) * 28'(modes_ff[mi_ff].variance);
            state_in = gmmbg_pkg::S_TEST;
         end

         gmmbg_pkg::S_TEST: begin
            if (dist_ff < {2'b00, thr_ff, 4'h0}) begin
               fits_in   = 1'b1;
               wsum      = weight_ff + 18'(alpha);
               weight_in = wsum;
               ch_in     = gmmbg_pkg::CH_RED;
               if (wsum == '0) begin
                  k_in     = '0;
                  state_in = gmmbg_pkg::S_MEAN;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = {alpha, 16'h0000};
                  div_req.divisor  = 20'(wsum);
                  state_in         = gmmbg_pkg::S_KWAIT;
               end
            end else begin
               state_in = gmmbg_pkg::S_SAVE;
            end
         end

         gmmbg_pkg::S_KWAIT: begin
            if (div_rsp.done) begin
               k_in     = div_rsp.quotient;
               state_in = gmmbg_pkg::S_MEAN;
            end
         end

         gmmbg_pkg::S_MEAN: begin
            // mean moves toward the pixel by k, one channel a cycle
            mean_v = gmmbg_pkg::mean_get(modes_ff[mi_ff], ch_ff);
            px_v   = gmmbg_pkg::pixel_get(req_ff, ch_ff);
            d_ch   = {1'b0, px_v} - {1'b0, mean_v};
            mag16  = d_ch[16] ? 16'(-d_ch) : d_ch[15:0];
            prod33 = 33'(mag16) * 33'(k_ff);
            tmp    = modes_ff[mi_ff];
            modes_in[mi_ff] = gmmbg_pkg::mean_set(tmp, ch_ff,
               d_ch[16] ? (mean_v - prod33[31:16]) : (mean_v + prod33[31:16]));
            ch_in  = ch_ff + 2'd1;
            if (ch_ff == gmmbg_pkg::CH_BLUE) begin
               state_in = gmmbg_pkg::S_VAR;
            end
         end

         gmmbg_pkg::S_VAR: begin
            d_var   = {1'b0, dist_ff[33:8]} - 27'(modes_ff[mi_ff].variance);
            mag26   = d_var[26] ? 26'(-d_var) : d_var[25:0];
            prod43  = 43'(mag26) * 43'(k_ff);
            step_in = prod43[41:16];
            neg_in  = d_var[26];
            state_in = gmmbg_pkg::S_CLAMP;
         end

         gmmbg_pkg::S_CLAMP: begin
            vn = neg_ff ? (28'(modes_ff[mi_ff].variance) - 28'(step_ff))
                        : (28'(modes_ff[mi_ff].variance) + 28'(step_ff));
            if ($signed(vn) < $signed(28'(cfg.variance_floor))) begin
               vn = 28'(cfg.variance_floor);
            end
            if ($signed(vn) > $signed(28'(cfg.variance_ceiling))) begin
               vn = 28'(cfg.variance_ceiling);
            end
            modes_in[mi_ff].variance = vn[15:0];
            modes_in[mi_ff].weight   = wsat;
            total_in   = total_ff + 20'(wsat);
            pos_in     = mi_ff;
            bub_add_in = 1'b0;
            state_in   = gmmbg_pkg::S_BUBBLE;
         end

         gmmbg_pkg::S_SAVE: begin
            modes_in[mi_ff].weight = wsat;
            total_in = total_ff + 20'(wsat);
            state_in = gmmbg_pkg::S_NEXT;
         end

         gmmbg_pkg::S_BUBBLE: begin
            // move the entry up while it is not lighter than the one above
            if ((pos_ff != '0) &&
                !(modes_ff[pos_ff].weight < modes_ff[IDX_W'(pos_ff - IDX_W'(1))].weight)) begin
               modes_in[pos_ff] = modes_ff[IDX_W'(pos_ff - IDX_W'(1))];
               modes_in[IDX_W'(pos_ff - IDX_W'(1))] = modes_ff[pos_ff];
               pos_in = pos_ff - IDX_W'(1);
            end else begin
               state_in = bub_add_ff ? gmmbg_pkg::S_WRITE : gmmbg_pkg::S_NEXT;
            end
         end

         gmmbg_pkg::S_NEXT: begin
            if ((CNT_W'(mi_ff) + CNT_W'(1)) == n_ff) begin
               mi_in    = '0;
               state_in = gmmbg_pkg::S_RENORM;
            end else begin
               mi_in    = mi_ff + IDX_W'(1);
               state_in = gmmbg_pkg::S_DECAY;
            end
         end

         gmmbg_pkg::S_RENORM: begin
            if (total_ff == '0) begin
               state_in = gmmbg_pkg::S_ADD;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = {modes_ff[mi_ff].weight, 16'h0000};
               div_req.divisor  = total_ff;
               state_in         = gmmbg_pkg::S_RNWAIT;
            end
         end

         gmmbg_pkg::S_RNWAIT: begin
            if (div_rsp.done) begin
               modes_in[mi_ff].weight = div_rsp.quotient;
               if ((CNT_W'(mi_ff) + CNT_W'(1)) == n_ff) begin
                  state_in = gmmbg_pkg::S_ADD;
               end else begin
                  mi_in    = mi_ff + IDX_W'(1);
                  state_in = gmmbg_pkg::S_RENORM;
               end
            end
         end

         gmmbg_pkg::S_ADD: begin
            // no fit: new mode, or the weakest is replaced
            if (fits_ff || (alpha == '0)) begin
               state_in = gmmbg_pkg::S_WRITE;
            end else begin
               if (n_ff == CNT_W'(MAX_MODES)) begin
                  add_idx = IDX_W'(MAX_MODES - 1);
               end else begin
                  add_idx = IDX_W'(n_ff);
                  n_in    = n_ff + CNT_W'(1);
               end
               modes_in[add_idx].mean_r   = gmmbg_pkg::pixel_get(req_ff, gmmbg_pkg::CH_RED);
               modes_in[add_idx].mean_g   = gmmbg_pkg::pixel_get(req_ff, gmmbg_pkg::CH_GREEN);
               modes_in[add_idx].mean_b   = gmmbg_pkg::pixel_get(req_ff, gmmbg_pkg::CH_BLUE);
               modes_in[add_idx].variance = cfg.variance_initial;
               if (n_in == CNT_W'(1)) begin
                  modes_in[add_idx].weight = gmmbg_pkg::ONE_Q16;
                  state_in = gmmbg_pkg::S_WRITE;
               end else begin
                  modes_in[add_idx].weight = alpha;
                  mi_in    = '0;
                  state_in = gmmbg_pkg::S_ADECAY;
               end
            end
         end

         gmmbg_pkg::S_ADECAY: begin
            // older modes decay once more to make room for the new one
            prod34 = 34'(modes_ff[mi_ff].weight) * 34'(alpha_c);
            modes_in[mi_ff].weight = prod34[32:16];
            if ((CNT_W'(mi_ff) + CNT_W'(2)) == n_ff) begin
               pos_in     = IDX_W'(n_ff - CNT_W'(1));
               bub_add_in = 1'b1;
               state_in   = gmmbg_pkg::S_BUBBLE;
            end else begin
               mi_in = mi_ff + IDX_W'(1);
            end
         end

         gmmbg_pkg::S_WRITE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               ram_wr_en = 1'b1;
               ram_wr_data[ROW_W-1 -: CNT_W] = n_ff;
               for (int i = 0; i < MAX_MODES; i++) begin
                  ram_wr_data[i*MODE_W +: MODE_W] = modes_ff[i];
               end
               rsp_in.foreground = !bg_ff;
               rsp_in.bg_red     = (n_ff != '0) ? modes_ff[0].mean_r[15:8] : 8'h00;
               rsp_in.bg_green   = (n_ff != '0) ? modes_ff[0].mean_g[15:8] : 8'h00;
               rsp_in.bg_blue    = (n_ff != '0) ? modes_ff[0].mean_b[15:8] : 8'h00;
               rsp_valid_in      = 1'b1;
               state_in          = gmmbg_pkg::S_IDLE;
            end
         end

         default: state_in = gmmbg_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gmmbg_pkg::S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      idx_ff     <= idx_in;
      wrap_ff    <= wrap_in;
      n_ff       <= n_in;
      modes_ff   <= modes_in;
      mi_ff      <= mi_in;
      pos_ff     <= pos_in;
      ch_ff      <= ch_in;
      weight_ff  <= weight_in;
      total_ff   <= total_in;
      dist_ff    <= dist_in;
      thr_ff     <= thr_in;
      k_ff       <= k_in;
      step_ff    <= step_in;
      neg_ff     <= neg_in;
      fits_ff    <= fits_in;
      bg_ff      <= bg_in;
      bub_add_ff <= bub_add_in;
      rsp_ff     <= rsp_in;
   end

   // a new result beat only follows a row write back
   a_rsp_after_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == gmmbg_pkg::S_WRITE && ram_wr_en))
      else $error("result beat without write back");

   // the divider only reports while the sequencer waits for it
   a_div_expected: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == gmmbg_pkg::S_KWAIT || state_ff == gmmbg_pkg::S_RNWAIT))
      else $error("divider result while not waiting");

   // the written mode count stays within the mode capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gmmbg_pkg::S_WRITE && ram_wr_en) |-> (n_ff <= CNT_W'(MAX_MODES)))
      else $error("mode count above capacity");

   // no memory read during the clearing pass
   a_no_read_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gmmbg_pkg::S_CLEAR) |-> (!ram_rd_en && ram_wr_en))
      else $error("memory read while clearing");

endmodule
